// ===== design/esc_pkg.sv =====
// Shared types and constants for the environmental sensor compensation block.
package esc_pkg;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QDepthDef = 4;

  // Number of register stages in the front.
  localparam int unsigned FrontStages = 3;

  // Calibration register indexes.
  typedef enum logic [2:0] {
    CFG_TEMP      = 3'd0,
    CFG_PRESS_LO  = 3'd1,
    CFG_PRESS_HI  = 3'd2,
    CFG_PRESS_HUM = 3'd3,
    CFG_HUM       = 3'd4
  } cfg_idx_e;

  // Request handed from the front to the back: fine temperature and raw readings.
  typedef struct packed {
    logic signed [31:0] tf;
    logic [19:0]        ap;
    logic [15:0]        ah;
  } fine_item_t;

  // Side information that travels alongside the pressure divide.
  typedef struct packed {
    logic signed [31:0] temp;
    logic [16:0]        hum;
    logic               dz;
    logic               neg;
  } div_side_t;

  localparam logic signed [63:0] PressBias = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] HumMax    = 32'sd419430400;

endpackage

// ===== design/esc_front.sv =====
// Front: accepts raw samples and forms the fine temperature value.
module esc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [19:0]         raw_temperature_i,
  input  logic [19:0]         raw_pressure_i,
  input  logic [15:0]         raw_humidity_i,
  input  logic [47:0]         cal_temp_i,
  output logic                item_valid_o,
  output esc_pkg::fine_item_t item_o,
  output logic [1:0]          inflight_o
);
  import esc_pkg::*;

  logic signed [31:0] at_s, t1_s, t2_s, t3_s, a1_s, d_s;
  logic [FrontStages-1:0] vld_q;
  logic signed [31:0] m1_q, dd_q, x1_q, m2_q, tf_q;
  logic [19:0] ap1_q, ap2_q, ap3_q;
  logic [15:0] ah1_q, ah2_q, ah3_q;

  // Calibration fields and the first differences.
  assign at_s = $signed({12'b0, raw_temperature_i});
  assign t1_s = $signed({16'b0, cal_temp_i[15:0]});
  assign t2_s = 32'($signed(cal_temp_i[31:16]));
  assign t3_s = 32'($signed(cal_temp_i[47:32]));
  assign a1_s = (at_s >>> 3) - (t1_s <<< 1);
  assign d_s  = (at_s >>> 4) - t1_s;

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontStages-2:0], accept_i};
    end
  end

  // Three stages: products, scaled terms, fine temperature.
  always_ff @(posedge clk_i) begin
    m1_q  <= a1_s * t2_s;
    dd_q  <= d_s * d_s;
    ap1_q <= raw_pressure_i;
    ah1_q <= raw_humidity_i;
    x1_q  <= m1_q >>> 11;
    m2_q  <= (dd_q >>> 12) * t3_s;
    ap2_q <= ap1_q;
    ah2_q <= ah1_q;
    tf_q  <= x1_q + (m2_q >>> 14);
    ap3_q <= ap2_q;
    ah3_q <= ah2_q;
  end

  assign item_valid_o = vld_q[FrontStages-1];
  assign item_o.tf    = tf_q;
  assign item_o.ap    = ap3_q;
  assign item_o.ah    = ah3_q;
  assign inflight_o   = {1'b0, vld_q[0]} + {1'b0, vld_q[1]} + {1'b0, vld_q[2]};

endmodule

// ===== design/esc_queue.sv =====
// Short queue that decouples the front from the back.
module esc_queue #(
  parameter int unsigned Depth = esc_pkg::QDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  esc_pkg::fine_item_t               data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output esc_pkg::fine_item_t               data_o,
  output logic [$clog2(Depth+1)-1:0]        level_o
);
  import esc_pkg::*;

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  fine_item_t      mem_q [Depth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != CW'(Depth))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");
`endif

endmodule

// ===== design/esc_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module esc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [63:0]        num_i,
  input  logic [31:0]        den_i,
  input  esc_pkg::div_side_t side_i,
  output logic               valid_o,
  output logic [63:0]        quot_o,
  output esc_pkg::div_side_t side_o
);
  import esc_pkg::*;

  localparam int unsigned NW = 64;
  localparam int unsigned DW = 32;

  logic            vld_q  [NW];
  logic [DW-1:0]   rem_q  [NW];
  logic [NW-1:0]   nq_q   [NW];
  logic [DW-1:0]   den_q  [NW];
  div_side_t       side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            vld_in;
    logic [DW-1:0]   rem_in, den_in, trial, rem_nxt;
    logic [NW-1:0]   nq_in;
    div_side_t       side_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next dividend bit and try a subtract.
    assign trial   = {rem_in[DW-2:0], nq_in[NW-1]};
    assign ge      = (trial >= den_in);
    assign rem_nxt = ge ? (trial - den_in) : trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_nxt;
      nq_q[k]   <= {nq_in[NW-2:0], ge};
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = nq_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ===== design/esc_back.sv =====
// Back: pressure and humidity compensation, pressure divide and saturation.
module esc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  esc_pkg::fine_item_t item_i,
  input  logic [63:0]         cal_press_lo_i,
  input  logic [63:0]         cal_press_hi_i,
  input  logic [47:0]         cal_press_hum_i,
  input  logic [31:0]         cal_hum_i,
  output logic                valid_o,
  output logic signed [31:0]  temperature_centi_o,
  output logic signed [31:0]  pressure_q24_8_o,
  output logic [16:0]         humidity_q22_10_o,
  output logic                divide_by_zero_o
);
  import esc_pkg::*;

  localparam int unsigned NB = 11;
  localparam int unsigned NP = 4;

  // Calibration fields.
  logic signed [63:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
  logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

  assign c_p1 = $signed({48'b0, cal_press_lo_i[15:0]});
  assign c_p2 = 64'($signed(cal_press_lo_i[31:16]));
  assign c_p3 = 64'($signed(cal_press_lo_i[47:32]));
  assign c_p4 = 64'($signed(cal_press_lo_i[63:48]));
  assign c_p5 = 64'($signed(cal_press_hi_i[15:0]));
  assign c_p6 = 64'($signed(cal_press_hi_i[31:16]));
  assign c_p7 = 64'($signed(cal_press_hi_i[47:32]));
  assign c_p8 = 64'($signed(cal_press_hi_i[63:48]));
  assign c_p9 = 64'($signed(cal_press_hum_i[15:0]));
  assign c_h1 = $signed({24'b0, cal_press_hum_i[23:16]});
  assign c_h2 = 32'($signed(cal_press_hum_i[39:24]));
  assign c_h3 = $signed({24'b0, cal_press_hum_i[47:40]});
  assign c_h4 = $signed({20'b0, cal_hum_i[11:0]});
  assign c_h5 = $signed({20'b0, cal_hum_i[23:12]});
  assign c_h6 = 32'($signed(cal_hum_i[31:24]));

  logic [NB-1:0] bv_q;
  logic [NP-1:0] pv_q;

  logic signed [63:0] b1_v1_q;
  logic signed [31:0] b1_tm_q, b1_hv_q;
  logic [19:0]        b1_ap_q, b2_ap_q, b3_ap_q, b4_ap_q;
  logic [15:0]        b1_ah_q, b2_ah_q;
  logic signed [63:0] b2_sq_q, b2_pv5_q, b2_pv2_q;
  logic signed [31:0] b2_temp_q, b2_hs5_q, b2_hb_q, b2_hc_q;
  logic signed [63:0] b3_v2a_q, b3_s3_q, b3_v2b_q, b3_pv2_q;
  logic signed [31:0] b3_temp_q, b3_ha_q, b3_hb_q, b3_hc_q;
  logic signed [63:0] b4_v2_q, b4_vs_q;
  logic signed [31:0] b4_temp_q, b4_ha_q, b4_bc_q;
  logic signed [63:0] b5_vp_q, b5_nm_q;
  logic signed [31:0] b5_temp_q, b5_ha_q, b5_e_q;
  logic signed [63:0] b5_vp_sh;
  logic signed [63:0] b6_num_q, b7_num_q, b8_num_q, b9_num_q, b10_num_q;
  logic signed [31:0] b6_den_q, b7_den_q, b8_den_q, b9_den_q, b10_den_q;
  logic signed [31:0] b6_temp_q, b7_temp_q, b8_temp_q, b9_temp_q, b10_temp_q;
  logic signed [31:0] b6_ha_q, b6_fe_q, b7_ha_q, b7_f_q;
  logic signed [31:0] b8_hv2_q, b9_hv2_q, b9_gg_q, b10_hv2_q, b10_t_q;
  logic signed [31:0] b8_g;
  logic signed [31:0] b10_hv3, b10_hcl;
  logic [63:0]        b11_nmag_q;
  logic [31:0]        b11_dmag_q;
  div_side_t          b11_side_q;

  logic               dv_valid;
  logic [63:0]        dv_quot;
  div_side_t          dv_side;

  logic signed [63:0] p1_p_q, p2_p_q, p3_p_q;
  logic [63:0]        p2_ll_q;
  logic [31:0]        p2_hl_q;
  logic signed [63:0] p2_w2m_q, p3_w1m_q, p3_w2_q, p4_sum_q;
  logic signed [63:0] p1_ps, p4_r;
  div_side_t          p1_side_q, p2_side_q, p3_side_q, p4_side_q;
  logic signed [31:0] p4_sat;

  // Valid chains for the stages before and after the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= '0;
      pv_q    <= '0;
      valid_o <= 1'b0;
    end else begin
      bv_q    <= {bv_q[NB-2:0], item_valid_i};
      pv_q    <= {pv_q[NP-2:0], dv_valid};
      valid_o <= pv_q[NP-1];
    end
  end

  // Stages one to five: polynomial terms of the pressure and humidity formulas.
  always_ff @(posedge clk_i) begin
    b1_v1_q   <= 64'($signed(item_i.tf)) - 64'sd128000;
    b1_tm_q   <= $signed(item_i.tf) * 32'sd5;
    b1_hv_q   <= $signed(item_i.tf) - 32'sd76800;
    b1_ap_q   <= item_i.ap;
    b1_ah_q   <= item_i.ah;

    b2_sq_q   <= b1_v1_q * b1_v1_q;
    b2_pv5_q  <= b1_v1_q * c_p5;
    b2_pv2_q  <= b1_v1_q * c_p2;
    b2_temp_q <= (b1_tm_q + 32'sd128) >>> 8;
    b2_hs5_q  <= c_h5 * b1_hv_q;
    b2_hb_q   <= b1_hv_q * c_h6;
    b2_hc_q   <= b1_hv_q * c_h3;
    b2_ap_q   <= b1_ap_q;
    b2_ah_q   <= b1_ah_q;

    b3_v2a_q  <= b2_sq_q * c_p6;
    b3_s3_q   <= b2_sq_q * c_p3;
    b3_v2b_q  <= b2_pv5_q <<< 17;
    b3_pv2_q  <= b2_pv2_q;
    b3_temp_q <= b2_temp_q;
    b3_ha_q   <= (($signed({16'b0, b2_ah_q}) <<< 14) - (c_h4 <<< 20) - b2_hs5_q
                  + 32'sd16384) >>> 15;
    b3_hb_q   <= b2_hb_q >>> 10;
    b3_hc_q   <= (b2_hc_q >>> 11) + 32'sd32768;
    b3_ap_q   <= b2_ap_q;

    b4_v2_q   <= b3_v2a_q + b3_v2b_q + (c_p4 <<< 35);
    b4_vs_q   <= (b3_s3_q >>> 8) + (b3_pv2_q <<< 12);
    b4_bc_q   <= b3_hb_q * b3_hc_q;
    b4_ha_q   <= b3_ha_q;
    b4_temp_q <= b3_temp_q;
    b4_ap_q   <= b3_ap_q;

    b5_vp_q   <= (PressBias + b4_vs_q) * c_p1;
    b5_nm_q   <= ((64'sd1048576 - $signed({44'b0, b4_ap_q})) <<< 31) - b4_v2_q;
    b5_e_q    <= (b4_bc_q >>> 10) + 32'sd2097152;
    b5_ha_q   <= b4_ha_q;
    b5_temp_q <= b4_temp_q;
  end

  assign b5_vp_sh = b5_vp_q >>> 33;
  assign b8_g     = b8_hv2_q >>> 15;

  // Stages six to ten: divider operands, then the rest of the humidity terms.
  always_ff @(posedge clk_i) begin
    b6_den_q   <= b5_vp_sh[31:0];
    b6_num_q   <= b5_nm_q * 64'sd3125;
    b6_fe_q    <= b5_e_q * c_h2;
    b6_ha_q    <= b5_ha_q;
    b6_temp_q  <= b5_temp_q;

    b7_f_q     <= (b6_fe_q + 32'sd8192) >>> 14;
    b7_ha_q    <= b6_ha_q;
    b7_den_q   <= b6_den_q;
    b7_num_q   <= b6_num_q;
    b7_temp_q  <= b6_temp_q;

    b8_hv2_q   <= b7_ha_q * b7_f_q;
    b8_den_q   <= b7_den_q;
    b8_num_q   <= b7_num_q;
    b8_temp_q  <= b7_temp_q;

    b9_gg_q    <= b8_g * b8_g;
    b9_hv2_q   <= b8_hv2_q;
    b9_den_q   <= b8_den_q;
    b9_num_q   <= b8_num_q;
    b9_temp_q  <= b8_temp_q;

    b10_t_q    <= (b9_gg_q >>> 7) * c_h1;
    b10_hv2_q  <= b9_hv2_q;
    b10_den_q  <= b9_den_q;
    b10_num_q  <= b9_num_q;
    b10_temp_q <= b9_temp_q;
  end

  // Humidity clamp.
  assign b10_hv3 = b10_hv2_q - (b10_t_q >>> 4);

  always_comb begin
    priority if (b10_hv3 < 32'sd0) begin
      b10_hcl = 32'sd0;
    end else if (b10_hv3 > HumMax) begin
      b10_hcl = HumMax;
    end else begin
      b10_hcl = b10_hv3;
    end
  end

  // Stage eleven: signs and magnitudes for the divider.
  always_ff @(posedge clk_i) begin
    b11_nmag_q      <= b10_num_q[63] ? 64'(-b10_num_q) : 64'(b10_num_q);
    b11_dmag_q      <= b10_den_q[31] ? 32'(-b10_den_q) : 32'(b10_den_q);
    b11_side_q.neg  <= b10_num_q[63] ^ b10_den_q[31];
    b11_side_q.dz   <= (b10_den_q == 32'sd0);
    b11_side_q.temp <= b10_temp_q;
    b11_side_q.hum  <= b10_hcl[28:12];
  end

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bv_q[NB-1]),
    .num_i   (b11_nmag_q),
    .den_i   (b11_dmag_q),
    .side_i  (b11_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  assign p1_ps = p1_p_q >>> 13;

  // Post-divide correction terms; the square of the scaled pressure is built
  // modulo 2^64 from two 32 by 32 products of its halves.
  always_ff @(posedge clk_i) begin
    p1_p_q    <= dv_side.neg ? -$signed(dv_quot) : $signed(dv_quot);
    p1_side_q <= dv_side;

    p2_ll_q   <= 64'(p1_ps[31:0]) * 64'(p1_ps[31:0]);
    p2_hl_q   <= p1_ps[63:32] * p1_ps[31:0];
    p2_w2m_q  <= c_p8 * p1_p_q;
    p2_p_q    <= p1_p_q;
    p2_side_q <= p1_side_q;

    p3_w1m_q  <= $signed(p2_ll_q + {p2_hl_q[30:0], 33'b0}) * c_p9;
    p3_w2_q   <= p2_w2m_q >>> 19;
    p3_p_q    <= p2_p_q;
    p3_side_q <= p2_side_q;

    p4_sum_q  <= p3_p_q + (p3_w1m_q >>> 25) + p3_w2_q;
    p4_side_q <= p3_side_q;
  end

  // Final scale and saturation to the signed 32-bit range.
  assign p4_r = (p4_sum_q >>> 8) + (c_p7 <<< 4);

  always_comb begin
    priority if (p4_r > 64'sd2147483647) begin
      p4_sat = 32'sh7FFF_FFFF;
    end else if (p4_r < -64'sd2147483648) begin
      p4_sat = 32'sh8000_0000;
    end else begin
      p4_sat = p4_r[31:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    temperature_centi_o <= p4_side_q.temp;
    humidity_q22_10_o   <= p4_side_q.hum;
    divide_by_zero_o    <= p4_side_q.dz;
    pressure_q24_8_o    <= p4_side_q.dz ? 32'sd0 : p4_sat;
  end

endmodule

// ===== design/env_sensor_compensation.sv =====
// A result strobes on valid_o once its request has passed the front, the queue and the back.
// Throughput: one request per cycle while busy_o is low; the 64-stage pressure divider is fully pipelined.
// busy_o rises only when the front-to-back queue could not take every request in flight.
// The receiver cannot stall: each result is shown for exactly one cycle on valid_o.
// Reset is asynchronous, active low, and clears the valid chains, queue pointers and calibration registers.
// Top level of the environmental sensor compensation block.
module env_sensor_compensation #(
  parameter int unsigned QDepth = esc_pkg::QDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [15:0]        raw_humidity_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output logic               valid_o,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] pressure_q24_8_o,
  output logic [16:0]        humidity_q22_10_o,
  output logic               divide_by_zero_o
);
  import esc_pkg::*;

  localparam int unsigned CW = $clog2(QDepth + 1);
  localparam int unsigned LW = $clog2(QDepth + 4);

  logic [47:0] cal_temp_q, cal_press_hum_q;
  logic [63:0] cal_press_lo_q, cal_press_hi_q;
  logic [31:0] cal_hum_q;

  logic        accept;
  logic        f_valid;
  fine_item_t  f_item;
  logic [1:0]  f_inflight;
  logic        q_valid;
  fine_item_t  q_item;
  logic [CW-1:0] q_level;

  // Calibration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q      <= '0;
      cal_press_lo_q  <= '0;
      cal_press_hi_q  <= '0;
      cal_press_hum_q <= '0;
      cal_hum_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP:      cal_temp_q      <= cfg_data_i[47:0];
        CFG_PRESS_LO:  cal_press_lo_q  <= cfg_data_i;
        CFG_PRESS_HI:  cal_press_hi_q  <= cfg_data_i;
        CFG_PRESS_HUM: cal_press_hum_q <= cfg_data_i[47:0];
        CFG_HUM:       cal_hum_q       <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new requests when the queue could not absorb everything in the front.
  assign busy_o = (LW'(q_level) + LW'(f_inflight)) > LW'(QDepth);
  assign accept = start_i && !busy_o;

  esc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_humidity_i    (raw_humidity_i),
    .cal_temp_i        (cal_temp_q),
    .item_valid_o      (f_valid),
    .item_o            (f_item),
    .inflight_o        (f_inflight)
  );

  esc_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_item),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_item),
    .level_o (q_level)
  );

  esc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .item_valid_i        (q_valid),
    .item_i              (q_item),
    .cal_press_lo_i      (cal_press_lo_q),
    .cal_press_hi_i      (cal_press_hi_q),
    .cal_press_hum_i     (cal_press_hum_q),
    .cal_hum_i           (cal_hum_q),
    .valid_o             (valid_o),
    .temperature_centi_o (temperature_centi_o),
    .pressure_q24_8_o    (pressure_q24_8_o),
    .humidity_q22_10_o   (humidity_q22_10_o),
    .divide_by_zero_o    (divide_by_zero_o)
  );

`ifndef ASSERT_OFF
  a_dz_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && divide_by_zero_o |-> pressure_q24_8_o == 32'sd0)
    else $error("pressure not forced to zero on a zero divisor");
  a_busy_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (q_level != '0) || (f_inflight != 2'd0))
    else $error("busy with an empty queue and front");
`endif

endmodule
